// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define PRQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// same-cycle implication
`define PRQ_ASSERT_IMPL(label, ante, cons, msg) \
    `PRQ_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: design/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// shared types and codes of the priority request admission queue
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam logic [1:0] OP_SUBMIT  = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PAUSE   = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] KIND_ACCEPT  = 3'd0;
    localparam logic [2:0] KIND_REJECT  = 3'd1;
    localparam logic [2:0] KIND_START   = 3'd2;
    localparam logic [2:0] KIND_RELEASE = 3'd3;
    localparam logic [2:0] KIND_PAUSE   = 3'd4;

    localparam int PADDR_W = 3;
    localparam logic REG_MAX_ACTIVE = 1'b0;
    localparam logic REG_MAX_QUEUED = 1'b1;

    localparam logic [4:0] MAX_ACTIVE_RST = 5'd6;
    localparam logic [7:0] MAX_QUEUED_RST = 8'd128;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] id;
        logic [2:0]  prio;
        logic        pause;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic        found;
        logic [7:0]  queued;
        logic [4:0]  active;
        logic        last;
    } t_result;

endpackage

// File: design/priority_request_admission_queue.sv
// a submit walks the waiting queue from the tail, one entry per cycle
// a release compacts the whole queue, one entry per cycle
// each start follows a registered head read from the queue ram
// results leave through an output register; a two-entry command buffer takes new input meanwhile
// synchronous active-low reset empties the queue and active set, unpauses, restores limits
// ----------------------------------------------------------------------------
// priority_request_admission_queue
// priority ordered admission queue with a bounded active set and apb config
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_request_admission_queue #(
    parameter int QUEUE_DEPTH   = 128,
    parameter int ACTIVE_SLOTS  = 16,
    parameter int PRIORITY_BITS = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prq_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic [15:0]                   i_request_id,
    input  logic [2:0]                    i_priority_req,
    input  logic                          i_pause_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_kind,
    output logic [15:0]                   o_result_id,
    output logic                          o_found,
    output logic [7:0]                    o_queued_count,
    output logic [4:0]                    o_active_count,
    output logic                          o_last
);

    logic [4:0]       r_max_active;
    logic [7:0]       r_max_queued;
    logic             cfg_wr;
    logic             cmd_valid, cmd_ready;
    prq_pkg::t_cmd    cmd;
    prq_pkg::t_result res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_active <= prq_pkg::MAX_ACTIVE_RST;
            r_max_queued <= prq_pkg::MAX_QUEUED_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == prq_pkg::REG_MAX_ACTIVE) begin
                r_max_active <= pwdata[4:0];
            end else begin
                r_max_queued <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == prq_pkg::REG_MAX_QUEUED) ? {24'd0, r_max_queued}
                                                          : {27'd0, r_max_active};

    prq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_request_id   (i_request_id),
        .i_priority_req (i_priority_req),
        .i_pause_value  (i_pause_value),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_ready    (cmd_ready)
    );

    prq_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .ACTIVE_SLOTS  (ACTIVE_SLOTS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_ready  (cmd_ready),
        .i_max_active (r_max_active),
        .i_max_queued (r_max_queued),
        .o_res_valid  (o_out_valid),
        .o_res        (res),
        .i_res_ready  (i_out_ready)
    );

    assign o_kind         = res.kind;
    assign o_result_id    = res.id;
    assign o_found        = res.found;
    assign o_queued_count = res.queued;
    assign o_active_count = res.active;
    assign o_last         = res.last;

    `PRQ_ASSERT_IMPL(a_found_only_release, o_out_valid && (o_kind != prq_pkg::KIND_RELEASE), !o_found, "found set on a non-release result")
    `PRQ_ASSERT_IMPL(a_active_bound, o_out_valid, 32'(o_active_count) <= ACTIVE_SLOTS, "active count above slot count")
    `PRQ_ASSERT_IMPL(a_pause_id_zero, o_out_valid && (o_kind == prq_pkg::KIND_PAUSE), o_result_id == 16'd0, "pause ack with id")

endmodule

// File: design/prq_ram.sv
// ----------------------------------------------------------------------------
// prq_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module prq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/prq_front.sv
// ----------------------------------------------------------------------------
// prq_front
// accepts request transactions, drops OP_NONE operations, buffers commands
// ----------------------------------------------------------------------------
module prq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_operation,
    input  logic [15:0]    i_request_id,
    input  logic [2:0]     i_priority_req,
    input  logic           i_pause_value,
    output logic           o_cmd_valid,
    output prq_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_ready
);

    prq_pkg::t_cmd r_buf [2];
    logic          r_wp, n_wp;
    logic          r_rp, n_rp;
    logic [1:0]    r_cnt, n_cnt;
    logic          push, pop;
    prq_pkg::t_cmd cmd_in;

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_buf[r_rp];

    assign cmd_in.op    = i_operation;
    assign cmd_in.id    = i_request_id;
    assign cmd_in.prio  = i_priority_req;
    assign cmd_in.pause = i_pause_value;

    assign push = i_in_valid && o_in_ready && (i_operation != prq_pkg::OP_NONE);
    assign pop  = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= cmd_in;
        end
    end

endmodule

// File: design/prq_back.sv
// ----------------------------------------------------------------------------
// prq_back
// sequencer that walks the waiting queue, keeps the active set, emits results
// ----------------------------------------------------------------------------
module prq_back #(
    parameter int QUEUE_DEPTH   = 128,
    parameter int ACTIVE_SLOTS  = 16,
    parameter int PRIORITY_BITS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  prq_pkg::t_cmd     i_cmd,
    output logic              o_cmd_ready,
    input  logic [4:0]        i_max_active,
    input  logic [7:0]        i_max_queued,
    output logic              o_res_valid,
    output prq_pkg::t_result  o_res,
    input  logic              i_res_ready
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
    localparam int TW  = $clog2(ACTIVE_SLOTS + 1);
    localparam int PB  = PRIORITY_BITS;
    localparam int EW  = 16 + PB;
    localparam int LW  = (TW > 5) ? TW : 5;
    localparam int QLW = (CW > 8) ? CW : 8;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS      = 3'd1;
    localparam logic [2:0] S_INS_HEAD = 3'd2;
    localparam logic [2:0] S_REL      = 3'd3;
    localparam logic [2:0] S_EMIT     = 3'd4;
    localparam logic [2:0] S_DISP     = 3'd5;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, l};
        if (s >= (AW+1)'(QUEUE_DEPTH)) begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [PB-1:0] f_prio(input logic [2:0] p);
        logic [7:0]    pw;
        logic [PB-1:0] q;
        pw = {5'd0, p};
        for (int i = 0; i < PB; i++) begin
            q[i] = pw[i];
        end
        return q;
    endfunction

    function automatic logic [7:0] f_q8(input logic [CW-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[7:0];
    endfunction

    function automatic logic [4:0] f_a5(input logic [TW-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[4:0];
    endfunction

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_wr, n_wr;
    logic [15:0]      r_id, n_id;
    logic [PB-1:0]    r_prio, n_prio;
    logic             r_found, n_found;
    logic [2:0]       r_kind, n_kind;
    logic [TW-1:0]    r_starts, n_starts;
    logic             r_paused, n_paused;
    logic [TW-1:0]    r_total, n_total;
    logic             r_slot_valid [ACTIVE_SLOTS];
    logic             n_slot_valid [ACTIVE_SLOTS];
    logic [15:0]      r_slot_id [ACTIVE_SLOTS];
    logic             slot_we;
    logic [SW-1:0]    slot_widx;
    logic             r_ov, n_ov;
    prq_pkg::t_result r_out, n_out;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [EW-1:0]    ram_wdata, ram_rdata;
    logic [15:0]      rd_id;
    logic [PB-1:0]    rd_prio;

    logic [15:0]      key;
    logic             match, free;
    logic [SW-1:0]    match_idx, free_idx;

    logic [QLW-1:0]   qlim, mq;
    logic [LW-1:0]    alim, ma;
    logic             can_emit, cond;
    logic [AW-1:0]    next_head;
    logic [CW-1:0]    cnt_dec;
    logic [TW-1:0]    tot_inc, starts_inc;
    logic [CW-1:0]    wr_inc;

    prq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_id   = ram_rdata[EW-1:PB];
    assign rd_prio = ram_rdata[PB-1:0];

    assign key = (r_state == S_IDLE) ? i_cmd.id : rd_id;

    always_comb begin
        match     = 1'b0;
        match_idx = '0;
        free      = 1'b0;
        free_idx  = '0;
        for (int i = ACTIVE_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_valid[i] && (r_slot_id[i] == key)) begin
                match     = 1'b1;
                match_idx = SW'(i);
            end
            if (!r_slot_valid[i]) begin
                free     = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    // effective limits
    always_comb begin
        mq   = QLW'(i_max_queued);
        qlim = (mq > QLW'(QUEUE_DEPTH)) ? QLW'(QUEUE_DEPTH) : mq;
        ma   = LW'(i_max_active);
        if (ma == '0) begin
            alim = LW'(1);
        end else if (ma > LW'(ACTIVE_SLOTS)) begin
            alim = LW'(ACTIVE_SLOTS);
        end else begin
            alim = ma;
        end
    end

    assign can_emit   = !r_ov || i_res_ready;
    assign cond       = !r_paused && (r_count != '0) && (LW'(r_total) < alim);
    assign next_head  = f_phys(r_head, AW'(1));
    assign cnt_dec    = r_count - CW'(1);
    assign starts_inc = r_starts + TW'(1);
    assign wr_inc     = r_wr + CW'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_idx     = r_idx;
        n_wr      = r_wr;
        n_id      = r_id;
        n_prio    = r_prio;
        n_found   = r_found;
        n_kind    = r_kind;
        n_starts  = r_starts;
        n_paused  = r_paused;
        n_total   = r_total;
        n_ov      = r_ov && !i_res_ready;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_head;
        ram_wdata = {r_id, r_prio};
        ram_re    = 1'b0;
        ram_raddr = r_head;
        slot_we   = 1'b0;
        slot_widx = free_idx;
        tot_inc   = r_total;
        o_cmd_ready = 1'b0;
        for (int i = 0; i < ACTIVE_SLOTS; i++) begin
            n_slot_valid[i] = r_slot_valid[i];
        end

        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_id    = i_cmd.id;
                    n_prio  = f_prio(i_cmd.prio);
                    n_found = 1'b0;
                    unique case (i_cmd.op)
                        prq_pkg::OP_SUBMIT: begin
                            if (QLW'(r_count) >= qlim) begin
                                n_kind  = prq_pkg::KIND_REJECT;
                                n_state = S_EMIT;
                            end else if (r_count == '0) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_head;
                                ram_wdata = {i_cmd.id, f_prio(i_cmd.prio)};
                                n_count   = r_count + CW'(1);
                                n_kind    = prq_pkg::KIND_ACCEPT;
                                n_state   = S_EMIT;
                            end else begin
                                n_idx     = AW'(cnt_dec);
                                ram_re    = 1'b1;
                                ram_raddr = f_phys(r_head, AW'(cnt_dec));
                                n_state   = S_INS;
                            end
                        end
                        prq_pkg::OP_RELEASE: begin
                            n_kind  = prq_pkg::KIND_RELEASE;
                            n_found = match;
                            if (match) begin
                                n_slot_valid[match_idx] = 1'b0;
                                if (r_total != '0) begin
                                    n_total = r_total - TW'(1);
                                end
                            end
                            n_idx = '0;
                            n_wr  = '0;
                            if (r_count == '0) begin
                                n_state = S_EMIT;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_state   = S_REL;
                            end
                        end
                        prq_pkg::OP_PAUSE: begin
                            n_paused = i_cmd.pause;
                            n_kind   = prq_pkg::KIND_PAUSE;
                            n_id     = 16'd0;
                            n_state  = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = f_phys(r_head, r_idx + AW'(1));
                if (rd_prio < r_prio) begin
                    ram_wdata = ram_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS_HEAD;
                    end else begin
                        n_idx     = r_idx - AW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = f_phys(r_head, r_idx - AW'(1));
                    end
                end else begin
                    ram_wdata = {r_id, r_prio};
                    n_count   = r_count + CW'(1);
                    n_kind    = prq_pkg::KIND_ACCEPT;
                    n_state   = S_EMIT;
                end
            end
            S_INS_HEAD: begin
                ram_we    = 1'b1;
                ram_waddr = r_head;
                ram_wdata = {r_id, r_prio};
                n_count   = r_count + CW'(1);
                n_kind    = prq_pkg::KIND_ACCEPT;
                n_state   = S_EMIT;
            end
            S_REL: begin
                if (rd_id == r_id) begin
                    n_found = 1'b1;
                    n_wr    = r_wr;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = f_phys(r_head, AW'(r_wr));
                    ram_wdata = ram_rdata;
                    n_wr      = wr_inc;
                end
                if ((CW'(r_idx) + CW'(1)) == r_count) begin
                    n_count = n_wr;
                    n_state = S_EMIT;
                end else begin
                    n_idx     = r_idx + AW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = f_phys(r_head, r_idx + AW'(1));
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    n_ov         = 1'b1;
                    n_out.kind   = r_kind;
                    n_out.id     = r_id;
                    n_out.found  = r_found;
                    n_out.queued = f_q8(r_count);
                    n_out.active = f_a5(r_total);
                    n_out.last   = !cond;
                    if (cond) begin
                        n_starts  = '0;
                        ram_re    = 1'b1;
                        ram_raddr = r_head;
                        n_state   = S_DISP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DISP: begin
                if (can_emit) begin
                    n_head   = next_head;
                    n_count  = cnt_dec;
                    n_starts = starts_inc;
                    if (!match && free) begin
                        slot_we   = 1'b1;
                        slot_widx = free_idx;
                        n_slot_valid[free_idx] = 1'b1;
                        tot_inc   = r_total + TW'(1);
                    end
                    n_total      = tot_inc;
                    n_ov         = 1'b1;
                    n_out.kind   = prq_pkg::KIND_START;
                    n_out.id     = rd_id;
                    n_out.found  = 1'b0;
                    n_out.queued = f_q8(cnt_dec);
                    n_out.active = f_a5(tot_inc);
                    if ((cnt_dec != '0) && (LW'(tot_inc) < alim)
                        && (starts_inc < TW'(ACTIVE_SLOTS))) begin
                        n_out.last = 1'b0;
                        ram_re     = 1'b1;
                        ram_raddr  = next_head;
                    end else begin
                        n_out.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_paused <= 1'b0;
            r_total  <= '0;
            r_ov     <= 1'b0;
            for (int i = 0; i < ACTIVE_SLOTS; i++) begin
                r_slot_valid[i] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
            r_paused <= n_paused;
            r_total  <= n_total;
            r_ov     <= n_ov;
            for (int i = 0; i < ACTIVE_SLOTS; i++) begin
                r_slot_valid[i] <= n_slot_valid[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wr     <= n_wr;
        r_id     <= n_id;
        r_prio   <= n_prio;
        r_found  <= n_found;
        r_kind   <= n_kind;
        r_starts <= n_starts;
        r_out    <= n_out;
        if (slot_we) begin
            r_slot_id[slot_widx] <= rd_id;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives submit, release and pause commands into the admission queue, tracks
// the waiting queue and active set alongside it, and checks every result
// transaction field by field; limits are reprogrammed over apb between phases
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_SLOTS = 16;
    localparam int N_DEPTH = 128;
    localparam int SETTLE = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int N_PHASES = 6;
    localparam int N_RANDOM = 22;

    typedef struct {
        prq_pkg::t_cmd cmd;
        bit            chk;
        logic [2:0]    kind;
        logic [7:0]    queued;
        logic [4:0]    active;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [prq_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = '0;
    logic [15:0] i_request_id = '0;
    logic [2:0]  i_priority_req = '0;
    logic        i_pause_value = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [15:0] o_result_id;
    logic        o_found;
    logic [7:0]  o_queued_count;
    logic [4:0]  o_active_count;
    logic        o_last;

    priority_request_admission_queue dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow state
    logic [15:0] wait_ids[$];
    logic [2:0]  wait_prios[$];
    bit          slot_busy[N_SLOTS];
    logic [15:0] slot_owner[N_SLOTS];
    int          n_active;
    bit          paused;
    int          lim_active_reg = 32'(prq_pkg::MAX_ACTIVE_RST);
    int          lim_queued_reg = 32'(prq_pkg::MAX_QUEUED_RST);
    prq_pkg::t_result step_results[$];
    prq_pkg::t_result pending_results[$];

    int  n_errors;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;
    int  stall_cycles;

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic void note(logic [2:0] kind, logic [15:0] id, logic found);
        prq_pkg::t_result r;
        r.kind = kind;
        r.id = id;
        r.found = found;
        r.queued = 8'(wait_ids.size());
        r.active = 5'(n_active);
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic prq_pkg::t_result admit_cmd(prq_pkg::t_cmd c);
        int pos, slot, starts, lim_act, lim_q;
        bit hit;
        logic [15:0] id;
        prq_pkg::t_result blank;
        blank = '0;
        step_results.delete();
        lim_act = lim_active_reg == 0 ? 1 : (lim_active_reg > N_SLOTS ? N_SLOTS : lim_active_reg);
        lim_q = lim_queued_reg > N_DEPTH ? N_DEPTH : lim_queued_reg;
        if (c.op == prq_pkg::OP_NONE) return blank;
        if (c.op == prq_pkg::OP_SUBMIT) begin
            if (wait_ids.size() >= lim_q) begin
                note(prq_pkg::KIND_REJECT, c.id, 1'b0);
            end else begin
                pos = 0;
                while (pos < wait_ids.size() && wait_prios[pos] >= c.prio) pos++;
                wait_ids.insert(pos, c.id);
                wait_prios.insert(pos, c.prio);
                note(prq_pkg::KIND_ACCEPT, c.id, 1'b0);
            end
        end else if (c.op == prq_pkg::OP_RELEASE) begin
            hit = 1'b0;
            for (int i = wait_ids.size() - 1; i >= 0; i--) begin
                if (wait_ids[i] == c.id) begin
                    wait_ids.delete(i);
                    wait_prios.delete(i);
                    hit = 1'b1;
                end
            end
            for (int i = 0; i < N_SLOTS; i++) begin
                if (slot_busy[i] && slot_owner[i] == c.id) begin
                    slot_busy[i] = 1'b0;
                    if (n_active > 0) n_active--;
                    hit = 1'b1;
                end
            end
            note(prq_pkg::KIND_RELEASE, c.id, hit);
        end else begin
            paused = c.pause;
            note(prq_pkg::KIND_PAUSE, 16'd0, 1'b0);
        end
        starts = 0;
        while (!paused && wait_ids.size() > 0 && n_active < lim_act && starts < N_SLOTS) begin
            id = wait_ids.pop_front();
            void'(wait_prios.pop_front());
            slot = -1;
            for (int i = 0; i < N_SLOTS; i++)
                if (slot < 0 && slot_busy[i] && slot_owner[i] == id) slot = i;
            if (slot < 0) begin
                for (int i = 0; i < N_SLOTS; i++)
                    if (slot < 0 && !slot_busy[i]) slot = i;
                if (slot >= 0) begin
                    slot_busy[slot] = 1'b1;
                    slot_owner[slot] = id;
                    n_active++;
                end
            end
            note(prq_pkg::KIND_START, id, 1'b0);
            starts++;
        end
        step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i]) pending_results.push_back(step_results[i]);
        return step_results[0];
    endfunction

    // caller is at a falling edge; returns at a falling edge
    task automatic drive_cmd(input prq_pkg::t_cmd c, output prq_pkg::t_result first);
        int n;
        i_in_valid = 1'b1;
        i_operation = c.op;
        i_request_id = c.id;
        i_priority_req = c.prio;
        i_pause_value = c.pause;
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        first = admit_cmd(c);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {reg_sel, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (reg_sel == prq_pkg::REG_MAX_ACTIVE) lim_active_reg = 32'(value[4:0]);
        else lim_queued_reg = 32'(value[7:0]);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic prq_pkg::t_cmd random_cmd();
        prq_pkg::t_cmd c;
        int sel;
        sel = $urandom_range(0, 99);
        c.op = sel < 50 ? prq_pkg::OP_SUBMIT : sel < 84 ? prq_pkg::OP_RELEASE
             : sel < 97 ? prq_pkg::OP_PAUSE : prq_pkg::OP_NONE;
        c.id = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 31));
        c.prio = 3'($urandom_range(0, 7));
        c.pause = $urandom_range(0, 9) < 3;
        return c;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        prq_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result kind", 32'(o_kind), 32'(0));
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind) report("kind", 32'(o_kind), 32'(want.kind));
                if (o_result_id !== want.id)
                    report("result_id", 32'(o_result_id), 32'(want.id));
                if (o_found !== want.found) report("found", 32'(o_found), 32'(want.found));
                if (o_queued_count !== want.queued)
                    report("queued", 32'(o_queued_count), 32'(want.queued));
                if (o_active_count !== want.active)
                    report("active", 32'(o_active_count), 32'(want.active));
                if (o_last !== want.last) report("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result receiver
    initial begin
        int n;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready = 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
                n = $urandom_range(1, 16);
                repeat (n) @(negedge i_clk);
            end
        end
    end

    initial begin
        t_row rows[$];
        prq_pkg::t_result first;
        prq_pkg::t_cmd c;
        int ph_active[N_PHASES] = '{1, 0, 16, 31, 3, 6};
        int ph_queued[N_PHASES] = '{3, 0, 255, 128, 8, 128};

        rows = '{
            '{'{prq_pkg::OP_PAUSE,   16'h0000, 3'd0, 1'b1}, 1, prq_pkg::KIND_PAUSE,   8'd0, 5'd0},
            '{'{prq_pkg::OP_SUBMIT,  16'h0000, 3'd7, 1'b0}, 1, prq_pkg::KIND_ACCEPT,  8'd1, 5'd0},
            '{'{prq_pkg::OP_SUBMIT,  16'hffff, 3'd0, 1'b1}, 1, prq_pkg::KIND_ACCEPT,  8'd2, 5'd0},
            '{'{prq_pkg::OP_SUBMIT,  16'h1234, 3'd7, 1'b0}, 1, prq_pkg::KIND_ACCEPT,  8'd3, 5'd0},
            '{'{prq_pkg::OP_SUBMIT,  16'h0000, 3'd3, 1'b0}, 1, prq_pkg::KIND_ACCEPT,  8'd4, 5'd0},
            '{'{prq_pkg::OP_RELEASE, 16'h5555, 3'd0, 1'b0}, 1, prq_pkg::KIND_RELEASE, 8'd4, 5'd0},
            '{'{prq_pkg::OP_NONE,    16'hffff, 3'd7, 1'b1}, 0, 3'd0, 8'd0, 5'd0},
            '{'{prq_pkg::OP_PAUSE,   16'hffff, 3'd7, 1'b0}, 1, prq_pkg::KIND_PAUSE,   8'd4, 5'd0},
            '{'{prq_pkg::OP_RELEASE, 16'h0000, 3'd7, 1'b1}, 0, 3'd0, 8'd0, 5'd0},
            '{'{prq_pkg::OP_RELEASE, 16'hffff, 3'd0, 1'b0}, 0, 3'd0, 8'd0, 5'd0},
            '{'{prq_pkg::OP_SUBMIT,  16'haaaa, 3'd5, 1'b0}, 0, 3'd0, 8'd0, 5'd0},
            '{'{prq_pkg::OP_SUBMIT,  16'h5555, 3'd2, 1'b1}, 0, 3'd0, 8'd0, 5'd0},
            '{'{prq_pkg::OP_SUBMIT,  16'h1234, 3'd1, 1'b0}, 0, 3'd0, 8'd0, 5'd0},
            '{'{prq_pkg::OP_RELEASE, 16'h1234, 3'd0, 1'b0}, 0, 3'd0, 8'd0, 5'd0}
        };

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            drive_cmd(rows[i].cmd, first);
            if (rows[i].chk && (first.kind !== rows[i].kind || first.queued !== rows[i].queued
                                || first.active !== rows[i].active))
                report("directed row", 32'(i), 32'({first.kind, first.queued, first.active}));
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            if (p == N_PHASES - 1) idle_on = 1'b0;
            apb_write(prq_pkg::REG_MAX_ACTIVE, 32'(ph_active[p]));
            apb_write(prq_pkg::REG_MAX_QUEUED, 32'(ph_queued[p]));
            if (p == 2) begin
                // fill the queue to its depth and submit past it, then unpause to release a burst of starts
                c = '{prq_pkg::OP_PAUSE, 16'h0, 3'd0, 1'b1};
                drive_cmd(c, first);
                for (int k = 0; k < 130; k++) begin
                    c = '{prq_pkg::OP_SUBMIT, 16'(k), 3'($urandom_range(0, 7)), 1'b0};
                    drive_cmd(c, first);
                end
                c = '{prq_pkg::OP_PAUSE, 16'h0, 3'd0, 1'b0};
                drive_cmd(c, first);
            end
            for (int k = 0; k < N_RANDOM; k++) begin
                if (p == 0 && k == 10) hold_req = 1'b1;
                drive_cmd(random_cmd(), first);
            end
        end

        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/prq_pkg.sv
design/prq_ram.sv
design/prq_front.sv
design/prq_back.sv
design/priority_request_admission_queue.sv
tb/tb_top.sv
